@@ hdl/arqsws_pkg.sv @@
// ----------------------------------------------------------------------------
// ARQ sliding-window sender package
// Field widths, codes, result beat type and parameter defaults used by the
// sender.
// ----------------------------------------------------------------------------
`default_nettype none

package arqsws_pkg;

  // Parameter defaults
  localparam int MAX_WINDOW_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  // Field widths
  localparam int KIND_W    = 2;
  localparam int HANDLE_W  = 8;
  localparam int LENGTH_W  = 10;
  localparam int SEQ_W     = 32;
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 2;
  localparam int WSIZE_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W   = HANDLE_W + LENGTH_W;

  // Register reset values
  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 4'd4;
  localparam logic               RESEND_ALL_RST  = 1'b1;

  // Input kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SEND    = 2'd0,
    KIND_RXACK   = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  // Result actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_SEND_NEW = 3'd0,
    ACT_RESEND   = 3'd1,
    ACT_ACK_SEND = 3'd2,
    ACT_WAIT     = 3'd3,
    ACT_DISMISS  = 3'd4,
    ACT_ACKED    = 3'd5,
    ACT_NONE     = 3'd6
  } action_e;

  // Result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE = 2'd0,
    CFG_RESEND_ALL  = 2'd1
  } cfg_idx_e;

  // One result beat
  typedef struct packed {
    action_e               action;
    logic [HANDLE_W-1:0]   handle;
    logic [LENGTH_W-1:0]   length;
    logic [SEQ_W-1:0]      seq;
    status_e               status;
    logic                  last;
  } result_t;

endpackage : arqsws_pkg

`default_nettype wire

@@ hdl/arqsws_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; read data registered and held while no
// read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module arqsws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule : arqsws_ram

`default_nettype wire

@@ hdl/arq_sliding_window_sender.sv @@
// ----------------------------------------------------------------------------
// ARQ sliding-window sender
// Sending side of a stop-and-wait / go-back-N / selective-repeat window.
// Frames sit in a slot RAM used as a ring of MAX_WINDOW places; requests that
// find the window full wait in a FIFO held in a second RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+-------------------------------
//  in       | in  | in_valid_i / in_stall_o    | kind, frame_handle,
//           |     |                            | frame_length, seq_number, is_nak
//  out      | out | out_valid_o / out_stall_i  | action, out_handle, out_length,
//           |     |                            | out_seq, status, last
//  cfg      | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  One item at a time. Single-result items pass the accept and decide steps.
//  Resends and ACK walks give n result beats, n <= MAX_WINDOW: one beat a
//  cycle when not stalled, paced by the read port of the slot or wait-queue RAM.
//  Reset clears the window and queue pointers; the RAMs need no clearing pass.
//  A stall on the output holds the walk in place; the result register keeps
//  its beat until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_sliding_window_sender #(
  parameter int MAX_WINDOW  = arqsws_pkg::MAX_WINDOW_DEF,
  parameter int QUEUE_DEPTH = arqsws_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [arqsws_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [arqsws_pkg::WSIZE_W-1:0]    cfg_data_i,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [arqsws_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [arqsws_pkg::HANDLE_W-1:0]   frame_handle_i,
  input  wire logic [arqsws_pkg::LENGTH_W-1:0]   frame_length_i,
  input  wire logic [arqsws_pkg::SEQ_W-1:0]      seq_number_i,
  input  wire logic                              is_nak_i,
  // results
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [arqsws_pkg::ACTION_W-1:0]        action_o,
  output logic [arqsws_pkg::HANDLE_W-1:0]        out_handle_o,
  output logic [arqsws_pkg::LENGTH_W-1:0]        out_length_o,
  output logic [arqsws_pkg::SEQ_W-1:0]           out_seq_o,
  output logic [arqsws_pkg::STATUS_W-1:0]        status_o,
  output logic                                   last_o
);

  import arqsws_pkg::*;

  localparam int SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;   // slot index
  localparam int CW  = $clog2(MAX_WINDOW + 1);                      // outstanding count
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1; // queue index
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);                     // queue fill

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_RESEND = 4'b0100,
    S_ACK    = 4'b1000
  } state_e;

  // slot index helpers (MAX_WINDOW need not be a power of two)
  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (32'(s) == MAX_WINDOW - 1) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] b,
                                             input logic [SW-1:0] o);
    logic [SW:0] sum;
    sum = {1'b0, b} + {1'b0, o};
    if (sum >= (SW+1)'(MAX_WINDOW)) begin
      sum = sum - (SW+1)'(MAX_WINDOW);
    end
    return sum[SW-1:0];
  endfunction

  function automatic logic [QW-1:0] q_inc(input logic [QW-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [WSIZE_W-1:0]    window_size_q;
  logic                  resend_all_q;
  logic [SEQ_W-1:0]      window_lower_q, window_lower_d;
  logic [SEQ_W-1:0]      window_upper_q, window_upper_d;
  logic [SW-1:0]         lower_slot_q, lower_slot_d;
  logic [SW-1:0]         upper_slot_q, upper_slot_d;
  logic [CW-1:0]         out_cnt_q, out_cnt_d;
  logic [QW-1:0]         wait_head_q, wait_head_d;
  logic [QW-1:0]         wait_tail_q, wait_tail_d;
  logic [QCW-1:0]        wait_count_q, wait_count_d;
  logic [CW-1:0]         walk_cnt_q, walk_cnt_d;
  logic [SW-1:0]         walk_slot_q, walk_slot_d;
  logic [SEQ_W-1:0]      walk_seq_q, walk_seq_d;
  logic                  out_valid_q;
  result_t               out_q, res_d;

  // captured item
  kind_e                 kind_q;
  logic [HANDLE_W-1:0]   handle_q;
  logic [LENGTH_W-1:0]   length_q;
  logic [SEQ_W-1:0]      num_q;
  logic                  nak_q;
  logic [SEQ_W-1:0]      dnum_q;   // received number minus window_lower

  // RAM ports
  logic                  slot_we, slot_re;
  logic [SW-1:0]         slot_waddr, slot_raddr;
  logic [ENTRY_W-1:0]    slot_wdata, slot_rdata;
  logic                  q_we, q_re;
  logic [QW-1:0]         q_waddr, q_raddr;
  logic [ENTRY_W-1:0]    q_wdata, q_rdata;

  logic                  in_fire, can_emit, emit;
  logic [CW-1:0]         eff_win;
  logic                  in_win;
  logic [SW-1:0]         sel_slot;
  logic                  go_dismiss, go_all, go_one, go_ack;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign can_emit    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // effective window: 0 acts as 1, clipped at MAX_WINDOW
  always_comb begin
    if (window_size_q == '0) begin
      eff_win = CW'(1);
    end else if (32'(window_size_q) > MAX_WINDOW) begin
      eff_win = CW'(MAX_WINDOW);
    end else begin
      eff_win = CW'(window_size_q);
    end
  end

  // window test and slot of the named frame
  assign in_win   = (dnum_q != '0) && (dnum_q <= SEQ_W'(out_cnt_q));
  assign sel_slot = slot_add(lower_slot_q, SW'(dnum_q - 32'd1));

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  arqsws_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  arqsws_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    window_lower_d = window_lower_q;
    window_upper_d = window_upper_q;
    lower_slot_d   = lower_slot_q;
    upper_slot_d   = upper_slot_q;
    out_cnt_d      = out_cnt_q;
    wait_head_d    = wait_head_q;
    wait_tail_d    = wait_tail_q;
    wait_count_d   = wait_count_q;
    walk_cnt_d     = walk_cnt_q;
    walk_slot_d    = walk_slot_q;
    walk_seq_d     = walk_seq_q;
    emit           = 1'b0;
    res_d          = '{action: ACT_NONE, handle: '0, length: '0, seq: '0,
                       status: ST_OK, last: 1'b1};
    slot_we        = 1'b0;
    slot_waddr     = upper_slot_q;
    slot_wdata     = {handle_q, length_q};
    slot_re        = 1'b0;
    slot_raddr     = lower_slot_q;
    q_we           = 1'b0;
    q_waddr        = wait_tail_q;
    q_wdata        = {handle_q, length_q};
    q_re           = 1'b0;
    q_raddr        = wait_head_q;
    go_dismiss     = 1'b0;
    go_all         = 1'b0;
    go_one         = 1'b0;
    go_ack         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        unique case (kind_q)
          KIND_SEND: begin
            res_d.handle = handle_q;
            res_d.length = length_q;
            if (out_cnt_q < eff_win) begin
              // room in the window: store and send
              res_d.action = ACT_SEND_NEW;
              res_d.seq    = window_upper_q + 32'd1;
              if (can_emit) begin
                slot_we        = 1'b1;
                window_upper_d = window_upper_q + 32'd1;
                upper_slot_d   = slot_inc(upper_slot_q);
                out_cnt_d      = out_cnt_q + 1'b1;
              end
            end else if (32'(wait_count_q) < QUEUE_DEPTH) begin
              // park in the wait queue
              res_d.action = ACT_WAIT;
              if (can_emit) begin
                q_we         = 1'b1;
                wait_tail_d  = q_inc(wait_tail_q);
                wait_count_d = wait_count_q + 1'b1;
              end
            end else begin
              res_d.status = ST_OVERFLOW;
            end
            if (can_emit) begin
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end
          KIND_RXACK: begin
            if (!in_win) begin
              go_dismiss = 1'b1;
            end else if (nak_q) begin
              go_all = resend_all_q;
              go_one = !resend_all_q;
            end else begin
              go_ack = 1'b1;
            end
          end
          KIND_TIMEOUT: begin
            if (resend_all_q) begin
              go_all = 1'b1;
            end else if (in_win) begin
              go_one = 1'b1;
            end else begin
              go_dismiss = 1'b1;
            end
          end
          KIND_UNKNOWN: begin
            res_d.status = ST_UNKNOWN;
            if (can_emit) begin
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase

        // received number outside the window
        if (go_dismiss) begin
          res_d.action = ACT_DISMISS;
          res_d.seq    = num_q;
          res_d.status = ST_OUTSIDE;
          if (can_emit) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end

        // whole-window resend; an empty window gives a single none beat
        if (go_all) begin
          if (out_cnt_q == '0) begin
            if (can_emit) begin
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            slot_re     = 1'b1;
            slot_raddr  = lower_slot_q;
            walk_slot_d = lower_slot_q;
            walk_cnt_d  = out_cnt_q;
            walk_seq_d  = window_lower_q + 32'd1;
            state_d     = S_RESEND;
          end
        end

        // resend of the named frame only
        if (go_one) begin
          slot_re     = 1'b1;
          slot_raddr  = sel_slot;
          walk_slot_d = sel_slot;
          walk_cnt_d  = CW'(1);
          walk_seq_d  = num_q;
          state_d     = S_RESEND;
        end

        // ACK: prefetch the queue head and walk up to the number
        if (go_ack) begin
          q_re       = 1'b1;
          q_raddr    = wait_head_q;
          walk_cnt_d = CW'(dnum_q);
          state_d    = S_ACK;
        end
      end

      S_RESEND: begin
        res_d.action = ACT_RESEND;
        res_d.handle = slot_rdata[ENTRY_W-1:LENGTH_W];
        res_d.length = slot_rdata[LENGTH_W-1:0];
        res_d.seq    = walk_seq_q;
        res_d.last   = (walk_cnt_q == CW'(1));
        if (can_emit) begin
          emit        = 1'b1;
          slot_re     = 1'b1;
          slot_raddr  = slot_inc(walk_slot_q);
          walk_slot_d = slot_inc(walk_slot_q);
          walk_cnt_d  = walk_cnt_q - 1'b1;
          walk_seq_d  = walk_seq_q + 32'd1;
          if (walk_cnt_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      S_ACK: begin
        res_d.last = (walk_cnt_q == CW'(1));
        if (wait_count_q != '0) begin
          res_d.action = ACT_ACK_SEND;
          res_d.handle = q_rdata[ENTRY_W-1:LENGTH_W];
          res_d.length = q_rdata[LENGTH_W-1:0];
          res_d.seq    = window_upper_q + 32'd1;
        end else begin
          res_d.action = ACT_ACKED;
          res_d.seq    = window_lower_q + 32'd1;
        end
        if (can_emit) begin
          emit           = 1'b1;
          window_lower_d = window_lower_q + 32'd1;
          lower_slot_d   = slot_inc(lower_slot_q);
          walk_cnt_d     = walk_cnt_q - 1'b1;
          if (wait_count_q != '0) begin
            // freed place goes to the queued frame
            slot_we        = 1'b1;
            slot_waddr     = upper_slot_q;
            slot_wdata     = q_rdata;
            window_upper_d = window_upper_q + 32'd1;
            upper_slot_d   = slot_inc(upper_slot_q);
            wait_head_d    = q_inc(wait_head_q);
            wait_count_d   = wait_count_q - 1'b1;
            q_re           = 1'b1;
            q_raddr        = q_inc(wait_head_q);
          end else begin
            out_cnt_d = out_cnt_q - 1'b1;
          end
          if (walk_cnt_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      window_size_q  <= WINDOW_SIZE_RST;
      resend_all_q   <= RESEND_ALL_RST;
      window_lower_q <= '0;
      window_upper_q <= '0;
      lower_slot_q   <= '0;
      upper_slot_q   <= '0;
      out_cnt_q      <= '0;
      wait_head_q    <= '0;
      wait_tail_q    <= '0;
      wait_count_q   <= '0;
      walk_cnt_q     <= '0;
      walk_slot_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      window_lower_q <= window_lower_d;
      window_upper_q <= window_upper_d;
      lower_slot_q   <= lower_slot_d;
      upper_slot_q   <= upper_slot_d;
      out_cnt_q      <= out_cnt_d;
      wait_head_q    <= wait_head_d;
      wait_tail_q    <= wait_tail_d;
      wait_count_q   <= wait_count_d;
      walk_cnt_q     <= walk_cnt_d;
      walk_slot_q    <= walk_slot_d;
      // result beat valid
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // configuration write
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_WINDOW_SIZE: window_size_q <= cfg_data_i;
          CFG_RESEND_ALL:  resend_all_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q   <= kind_e'(kind_i);
      handle_q <= frame_handle_i;
      length_q <= frame_length_i;
      num_q    <= seq_number_i;
      nak_q    <= is_nak_i;
      dnum_q   <= seq_number_i - window_lower_q;
    end
    walk_seq_q <= walk_seq_d;
    if (emit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = out_q.action;
  assign out_handle_o = out_q.handle;
  assign out_length_o = out_q.length;
  assign out_seq_o    = out_q.seq;
  assign status_o     = out_q.status;
  assign last_o       = out_q.last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_outcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(out_cnt_q) <= MAX_WINDOW)
    else $error("outstanding count above MAX_WINDOW");

  a_outcnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SEQ_W'(out_cnt_q) == (window_upper_q - window_lower_q))
    else $error("outstanding count out of step with window edges");

  a_wait_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wait_count_q) <= QUEUE_DEPTH)
    else $error("wait queue fill above depth");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res_d.last) |=> (state_q == S_IDLE))
    else $error("final beat loaded but sequencer not back to idle");

  a_walk_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACK) |-> !q_we)
    else $error("wait queue written during an ACK walk");

endmodule : arq_sliding_window_sender

`default_nettype wire
